// ===== hdl/pgc_pkg.sv =====
package pgc_pkg;

  localparam int WORD_BITS      = 32;
  localparam int PIXEL_BITS     = 32;
  localparam int FRACTION_BITS  = 16;
  localparam int CHAN_BITS      = 16;
  localparam int GAMMA_BITS     = 16;
  localparam int GAMMA_FRAC     = 12;
  localparam int SHIFT_BITS     = 5;
  localparam int EXP_PREC       = 30;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int LANE_LAT       = 3 * FRACTION_BITS + 6;

  localparam logic [GAMMA_BITS-1:0] BYPASS_GAMMA = GAMMA_BITS'(4096);
  localparam logic [WORD_BITS-1:0] PIX_MASK = (PIXEL_BITS >= WORD_BITS) ? {WORD_BITS{1'b1}} :
      WORD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INV_GAMMA    = 3'd0,
    REG_RED_SHIFT    = 3'd1,
    REG_GREEN_SHIFT  = 3'd2,
    REG_BLUE_SHIFT   = 3'd3,
    REG_CHANNEL_MASK = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SPEC_CALC,
    SPEC_ZERO,
    SPEC_FULL
  } spec_t;

  typedef struct packed {
    logic [GAMMA_BITS-1:0] inv_gamma;
    logic [SHIFT_BITS-1:0] red_shift;
    logic [SHIFT_BITS-1:0] green_shift;
    logic [SHIFT_BITS-1:0] blue_shift;
    logic [CHAN_BITS-1:0]  channel_mask;
  } cfg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]          pix;
    logic                          bypass;
    logic                          fmt_err;
    logic [2:0][CHAN_BITS-1:0]     chan;
  } entry_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] pix;
    logic                 bypass;
    logic                 fmt_err;
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    v = v_in;
    res = '0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_w > v) begin
        bit_w = bit_w >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_w != 64'd0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  // Root of two to the power minus two to the minus j, in Q0.30.
  function automatic logic [EXP_PREC-1:0] exp_root(input int j);
    logic [63:0] t;
    t = isqrt64(64'd1 << (2 * EXP_PREC - 1));
    for (int i = 2; i <= 24; i++) begin
      if (i <= j) begin
        t = isqrt64(t << EXP_PREC);
      end
    end
    return t[EXP_PREC-1:0];
  endfunction

endpackage

// ===== hdl/pgc_in_if.sv =====
interface pgc_in_if;
  logic                           valid;
  logic                           ready;
  logic [pgc_pkg::WORD_BITS-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

// ===== hdl/pgc_out_if.sv =====
interface pgc_out_if;
  logic                           valid;
  logic                           ready;
  logic [pgc_pkg::WORD_BITS-1:0]  pixel_out;
  logic                           format_error;

  modport source (output valid, output pixel_out, output format_error, input ready);
  modport sink (input valid, input pixel_out, input format_error, output ready);
endinterface

// ===== hdl/pgc_front.sv =====
module pgc_front (
  input  pgc_pkg::cfg_t   cfg,
  pgc_in_if.sink          pix_in,
  input  logic            full,
  output logic            push,
  output pgc_pkg::entry_t entry
);
  import pgc_pkg::*;

  logic [WORD_BITS-1:0] pix;

  assign pix_in.ready = !full;
  assign push = pix_in.valid && !full;
  assign pix = pix_in.pixel_in & PIX_MASK;

  always_comb begin
    entry.pix = pix;
    entry.bypass = (cfg.inv_gamma == BYPASS_GAMMA);
    entry.fmt_err = (cfg.inv_gamma != BYPASS_GAMMA) && (cfg.channel_mask == '0);
    entry.chan[0] = CHAN_BITS'(pix >> cfg.red_shift) & cfg.channel_mask;
    entry.chan[1] = CHAN_BITS'(pix >> cfg.green_shift) & cfg.channel_mask;
    entry.chan[2] = CHAN_BITS'(pix >> cfg.blue_shift) & cfg.channel_mask;
  end

endmodule

// ===== hdl/pgc_queue.sv =====
module pgc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pgc_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output pgc_pkg::entry_t entry
);
  import pgc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  entry_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNW-1:0]  count;
  logic            do_push;
  logic            do_pop;

  assign full = (count == CNW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign entry = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pgc_lane.sv =====
module pgc_lane (
  input  logic                              clk,
  input  logic                              adv,
  input  logic [pgc_pkg::CHAN_BITS-1:0]     chan_in,
  input  logic [pgc_pkg::CHAN_BITS-1:0]     mask,
  input  logic [pgc_pkg::GAMMA_BITS-1:0]    inv_gamma,
  output logic [pgc_pkg::CHAN_BITS-1:0]     chan_out
);
  import pgc_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int CW = CHAN_BITS;
  localparam int XW = F + 1;
  localparam int SW = $clog2(F + 1);
  localparam int NW = SW + F;
  localparam int EW = NW + GAMMA_BITS - GAMMA_FRAC;
  localparam int KW = EW - F;
  localparam int AW = EXP_PREC + 1;

  // Restoring divider, one quotient bit per stage.
  logic [CW-1:0] d_rem [F+1];
  logic [XW-1:0] d_q   [F+1];
  logic          d_cz  [F+1];

  for (genvar i = 0; i <= F; i++) begin : g_div
    logic [CW-1:0] rem_in;
    logic          nb;
    logic [XW-1:0] q_in;
    logic          cz_in;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = chan_in >> 1;
      assign nb = chan_in[0];
      assign q_in = '0;
      assign cz_in = (chan_in == '0);
    end else begin : g_rest
      assign rem_in = d_rem[i-1];
      assign nb = 1'b0;
      assign q_in = d_q[i-1];
      assign cz_in = d_cz[i-1];
    end

    assign trial = {rem_in, nb};
    assign diff = trial - {1'b0, mask};
    assign ge = (trial >= {1'b0, mask});

    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem[i] <= ge ? diff[CW-1:0] : trial[CW-1:0];
        d_q[i] <= q_in | (XW'(ge) << (F - i));
        d_cz[i] <= cz_in;
      end
    end
  end

  // Normalize to Q1.F.
  logic [XW-1:0] x;
  logic [SW-1:0] lead;
  logic [SW-1:0] sft;
  logic [XW-1:0] n_m;
  logic [SW-1:0] n_s;
  spec_t         n_spec;
  spec_t         x_spec;

  assign x = d_q[F];

  always_comb begin
    lead = '0;
    for (int b = 0; b < F; b++) begin
      if (x[b]) begin
        lead = SW'(b);
      end
    end
  end

  assign sft = SW'(F) - lead;

  always_comb begin
    if (d_cz[F] || x == '0) begin
      x_spec = SPEC_ZERO;
    end else if (x[F]) begin
      x_spec = SPEC_FULL;
    end else begin
      x_spec = SPEC_CALC;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_m <= x << sft;
      n_s <= sft;
      n_spec <= x_spec;
    end
  end

  // Log2 fraction by repeated squaring, one bit per stage.
  logic [XW-1:0] s_m    [F];
  logic [F-1:0]  s_frac [F];
  logic [SW-1:0] s_s    [F];
  spec_t         s_spec [F];

  for (genvar j = 1; j <= F; j++) begin : g_sq
    logic [XW-1:0]   m_in;
    logic [F-1:0]    frac_in;
    logic [SW-1:0]   s_in;
    spec_t           spec_in;
    logic [2*XW-1:0] sq;
    logic [XW:0]     sh;

    if (j == 1) begin : g_first
      assign m_in = n_m;
      assign frac_in = '0;
      assign s_in = n_s;
      assign spec_in = n_spec;
    end else begin : g_rest
      assign m_in = s_m[j-2];
      assign frac_in = s_frac[j-2];
      assign s_in = s_s[j-2];
      assign spec_in = s_spec[j-2];
    end

    assign sq = m_in * m_in;
    assign sh = sq[F+XW:F];

    always_ff @(posedge clk) begin
      if (adv) begin
        s_m[j-1] <= sh[XW] ? sh[XW:1] : sh[XW-1:0];
        s_frac[j-1] <= frac_in | (F'(sh[XW]) << (F - j));
        s_s[j-1] <= s_in;
        s_spec[j-1] <= spec_in;
      end
    end
  end

  // Log magnitude and exponent.
  logic [NW-1:0]            nn;
  spec_t                    nn_spec;
  logic [EW-1:0]            ee;
  spec_t                    ee_spec;
  logic [NW+GAMMA_BITS-1:0] ng;

  always_ff @(posedge clk) begin
    if (adv) begin
      nn <= {s_s[F-1], {F{1'b0}}} - NW'(s_frac[F-1]);
      nn_spec <= s_spec[F-1];
    end
  end

  assign ng = nn * inv_gamma;

  always_ff @(posedge clk) begin
    if (adv) begin
      ee <= ng[NW+GAMMA_BITS-1:GAMMA_FRAC];
      ee_spec <= nn_spec;
    end
  end

  // Exp2 of the fraction, one root factor per stage.
  logic [AW-1:0] x_a    [F];
  logic [EW-1:0] x_e    [F];
  spec_t         x_spc  [F];

  for (genvar j = 1; j <= F; j++) begin : g_exp
    localparam logic [EXP_PREC-1:0] ROOT = exp_root(j);
    logic [AW-1:0]          a_in;
    logic [EW-1:0]          e_in;
    spec_t                  spec_in;
    logic [AW+EXP_PREC-1:0] prod;

    if (j == 1) begin : g_first
      assign a_in = AW'(1) << EXP_PREC;
      assign e_in = ee;
      assign spec_in = ee_spec;
    end else begin : g_rest
      assign a_in = x_a[j-2];
      assign e_in = x_e[j-2];
      assign spec_in = x_spc[j-2];
    end

    assign prod = a_in * ROOT;

    always_ff @(posedge clk) begin
      if (adv) begin
        x_a[j-1] <= e_in[F-j] ? prod[AW+EXP_PREC-1:EXP_PREC] : a_in;
        x_e[j-1] <= e_in;
        x_spc[j-1] <= spec_in;
      end
    end
  end

  // Integer part of the exponent is a right shift.
  logic [KW-1:0] k;
  logic [XW-1:0] a_s;
  logic [XW-1:0] y;
  spec_t         y_spec;

  assign k = x_e[F-1][EW-1:F];
  assign a_s = x_a[F-1][EXP_PREC:EXP_PREC-F];

  always_ff @(posedge clk) begin
    if (adv) begin
      y <= (k > KW'(F)) ? '0 : (a_s >> k);
      y_spec <= x_spc[F-1];
    end
  end

  logic [XW+CW-1:0] scaled;

  assign scaled = y * mask;

  always_ff @(posedge clk) begin
    if (adv) begin
      case (y_spec)
        SPEC_ZERO: chan_out <= '0;
        SPEC_FULL: chan_out <= mask;
        default:   chan_out <= scaled[F+CW-1:F];
      endcase
    end
  end

endmodule

// ===== hdl/pgc_back.sv =====
module pgc_back (
  input  logic            clk,
  input  logic            rst,
  input  pgc_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  pgc_pkg::entry_t q_entry,
  output logic            q_pop,
  pgc_out_if.source       pix_out
);
  import pgc_pkg::*;

  logic                 adv;
  logic                 vld  [LANE_LAT];
  side_t                side [LANE_LAT];
  logic [CHAN_BITS-1:0] res  [3];
  logic [WORD_BITS-1:0] packed_pix;
  side_t                last;

  assign adv = !pix_out.valid || pix_out.ready;
  assign q_pop = adv && q_valid;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    pgc_lane u_lane (
      .clk       (clk),
      .adv       (adv),
      .chan_in   (q_entry.chan[c]),
      .mask      (cfg.channel_mask),
      .inv_gamma (cfg.inv_gamma),
      .chan_out  (res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= q_valid;
      for (int i = 1; i < LANE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{pix: q_entry.pix, bypass: q_entry.bypass, fmt_err: q_entry.fmt_err};
      for (int i = 1; i < LANE_LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign last = side[LANE_LAT-1];
  assign packed_pix = ((WORD_BITS'(res[0]) << cfg.red_shift) |
                       (WORD_BITS'(res[1]) << cfg.green_shift) |
                       (WORD_BITS'(res[2]) << cfg.blue_shift)) & PIX_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (adv) begin
      pix_out.valid <= vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_out.pixel_out <= (last.bypass || last.fmt_err) ? last.pix : packed_pix;
      pix_out.format_error <= last.fmt_err;
    end
  end

endmodule

// ===== hdl/pixel_gamma_correction.sv =====
// An accepted word passes through the queue, the lane stages and the output register to its result.
// Throughput is one word per cycle while the output is not stalled; the lanes are fully pipelined.
// A four-word queue between the front and the lanes lets each side stall on its own.
// Reset is synchronous and active high; it empties the queue and pipeline and loads
// the registers with inv_gamma 4096, shifts 16, 8 and 0, and channel_mask 255.
module pixel_gamma_correction (
  input  logic                                 clk,
  input  logic                                 rst,
  pgc_in_if.sink                               pix_in,
  pgc_out_if.source                            pix_out,
  input  logic                                 cfg_we,
  input  logic [pgc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pgc_pkg::GAMMA_BITS-1:0]       cfg_data
);
  import pgc_pkg::*;

  cfg_t   cfg;
  logic   full;
  logic   push;
  entry_t push_entry;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_gamma <= BYPASS_GAMMA;
      cfg.red_shift <= SHIFT_BITS'(16);
      cfg.green_shift <= SHIFT_BITS'(8);
      cfg.blue_shift <= SHIFT_BITS'(0);
      cfg.channel_mask <= CHAN_BITS'(255);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_GAMMA:    cfg.inv_gamma <= cfg_data;
        REG_RED_SHIFT:    cfg.red_shift <= cfg_data[SHIFT_BITS-1:0];
        REG_GREEN_SHIFT:  cfg.green_shift <= cfg_data[SHIFT_BITS-1:0];
        REG_BLUE_SHIFT:   cfg.blue_shift <= cfg_data[SHIFT_BITS-1:0];
        REG_CHANNEL_MASK: cfg.channel_mask <= cfg_data[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  pgc_front u_front (
    .cfg    (cfg),
    .pix_in (pix_in),
    .full   (full),
    .push   (push),
    .entry  (push_entry)
  );

  pgc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (q_pop),
    .valid      (q_valid),
    .entry      (q_entry)
  );

  pgc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .pix_out (pix_out)
  );

endmodule
